>>> sv/gha_pkg.sv
package gha_pkg;

  // Fixed field widths of the item and result channels
  localparam int unsigned GHA_OP_W      = 2;
  localparam int unsigned GHA_IDX_FLD_W = 10;
  localparam int unsigned GHA_VER_FLD_W = 16;
  localparam int unsigned GHA_ST_W      = 2;

  // Widest slot index and version over the legal parameter range
  localparam int unsigned GHA_IDX_MAX_W = 16;
  localparam int unsigned GHA_VER_MAX_W = 32;

  localparam logic [GHA_OP_W-1:0] GHA_OP_ALLOC   = 2'd0;
  localparam logic [GHA_OP_W-1:0] GHA_OP_RELEASE = 2'd1;
  localparam logic [GHA_OP_W-1:0] GHA_OP_CHECK   = 2'd2;

  localparam logic [GHA_ST_W-1:0] GHA_ST_OK      = 2'd0;
  localparam logic [GHA_ST_W-1:0] GHA_ST_FULL    = 2'd1;
  localparam logic [GHA_ST_W-1:0] GHA_ST_INVALID = 2'd2;

  // Table access request from the sequencer, sized for the widest configuration
  typedef struct packed {
    logic                     sp_we;
    logic [GHA_IDX_MAX_W-1:0] sp_waddr;
    logic [GHA_IDX_MAX_W-1:0] sp_wdata;
    logic [GHA_IDX_MAX_W-1:0] sp_raddr;
    logic                     dn_we;
    logic [GHA_IDX_MAX_W-1:0] dn_waddr;
    logic [GHA_IDX_MAX_W-1:0] dn_wdata_idx;
    logic [GHA_VER_MAX_W-1:0] dn_wdata_ver;
    logic [GHA_IDX_MAX_W-1:0] dn_raddr;
  } gha_mem_req_t;

  typedef struct packed {
    logic [GHA_IDX_FLD_W-1:0] result_index;
    logic [GHA_VER_FLD_W-1:0] result_version;
    logic                     handle_valid;
    logic [GHA_ST_W-1:0]      status;
  } gha_res_t;

endpackage

>>> sv/gha_if.sv
interface gha_in_if import gha_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [GHA_OP_W-1:0]      op;
  logic [GHA_IDX_FLD_W-1:0] handle_index;
  logic [GHA_VER_FLD_W-1:0] handle_version;

  modport source (output valid, op, handle_index, handle_version, input ready);
  modport sink (input valid, op, handle_index, handle_version, output ready);
endinterface

interface gha_out_if import gha_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [GHA_IDX_FLD_W-1:0] result_index;
  logic [GHA_VER_FLD_W-1:0] result_version;
  logic                     handle_valid;
  logic [GHA_ST_W-1:0]      status;

  modport source (output valid, result_index, result_version, handle_valid, status,
                  input ready);
  modport sink (input valid, result_index, result_version, handle_valid, status,
                output ready);
endinterface

>>> sv/generational_handle_allocator.sv
// Generational handle allocator. Each item (allocate, release or check) is
// carried by a sequencer that walks through registered reads of the sparse
// and dense tables; a release that swaps with the last alive entry adds the
// write states S_LAST_WAIT and S_SWAP. The sequencer takes no new item before
// it has handed the last result on. Input ready is high only while the
// sequencer is idle; results leave through an output register, so the next
// item may be accepted while a finished result still waits. The tables need
// no clearing after reset: only entries below the slot count are read.
module generational_handle_allocator import gha_pkg::*; #(
  parameter int unsigned MAX_SLOTS    = 1024,
  parameter int unsigned VERSION_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gha_in_if.sink    in_i,
  gha_out_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

  gha_mem_req_t            mem_req;
  logic [IDX_W-1:0]        sp_rdata;
  logic [IDX_W-1:0]        dn_rd_idx;
  logic [VERSION_BITS-1:0] dn_rd_ver;
  logic                    res_valid;
  logic                    res_ready;
  gha_res_t                res;
  logic [CNT_W-1:0]        alive_cnt;
  logic [CNT_W-1:0]        slot_cnt;

  logic                    out_valid_q, out_valid_d;
  gha_res_t                out_res_q;

  gha_seq #(
    .MAX_SLOTS    (MAX_SLOTS),
    .VERSION_BITS (VERSION_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .sp_rdata_i  (sp_rdata),
    .dn_rd_idx_i (dn_rd_idx),
    .dn_rd_ver_i (dn_rd_ver),
    .mem_req_o   (mem_req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .alive_o     (alive_cnt),
    .slot_o      (slot_cnt)
  );

  gha_store #(
    .MAX_SLOTS    (MAX_SLOTS),
    .VERSION_BITS (VERSION_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .mem_req_i   (mem_req),
    .sp_rdata_o  (sp_rdata),
    .dn_rd_idx_o (dn_rd_idx),
    .dn_rd_ver_o (dn_rd_ver)
  );

  // Output register: load when empty or draining this cycle
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_index   = out_res_q.result_index;
  assign out_o.result_version = out_res_q.result_version;
  assign out_o.handle_valid   = out_res_q.handle_valid;
  assign out_o.status         = out_res_q.status;

  // The sequencer holds off new items while one is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while an item is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (alive_cnt <= slot_cnt) && (32'(slot_cnt) <= MAX_SLOTS))
    else $error("alive count exceeds slot count or capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_o.valid && (out_o.status != GHA_ST_OK) |-> !out_o.handle_valid)
    else $error("failed operation reported as valid");

endmodule

>>> sv/gha_store.sv
module gha_store import gha_pkg::*; #(
  parameter int unsigned MAX_SLOTS    = 1024,
  parameter int unsigned VERSION_BITS = 16,
  localparam int unsigned IDX_W       = $clog2(MAX_SLOTS)
) (
  input  logic                    clk_i,
  input  gha_mem_req_t            mem_req_i,
  output logic [IDX_W-1:0]        sp_rdata_o,
  output logic [IDX_W-1:0]        dn_rd_idx_o,
  output logic [VERSION_BITS-1:0] dn_rd_ver_o
);

  // Sparse: slot index -> dense position. Dense: {slot index, version}.
  logic [IDX_W-1:0]              sparse_mem [MAX_SLOTS];
  logic [IDX_W+VERSION_BITS-1:0] dense_mem  [MAX_SLOTS];

  always_ff @(posedge clk_i) begin
    if (mem_req_i.sp_we) begin
      sparse_mem[mem_req_i.sp_waddr[IDX_W-1:0]] <= mem_req_i.sp_wdata[IDX_W-1:0];
    end
    if (mem_req_i.dn_we) begin
      dense_mem[mem_req_i.dn_waddr[IDX_W-1:0]] <=
          {mem_req_i.dn_wdata_idx[IDX_W-1:0], mem_req_i.dn_wdata_ver[VERSION_BITS-1:0]};
    end
    sp_rdata_o                 <= sparse_mem[mem_req_i.sp_raddr[IDX_W-1:0]];
    {dn_rd_idx_o, dn_rd_ver_o} <= dense_mem[mem_req_i.dn_raddr[IDX_W-1:0]];
  end

endmodule

>>> sv/gha_seq.sv
module gha_seq import gha_pkg::*; #(
  parameter int unsigned MAX_SLOTS    = 1024,
  parameter int unsigned VERSION_BITS = 16,
  localparam int unsigned IDX_W       = $clog2(MAX_SLOTS),
  localparam int unsigned CNT_W       = $clog2(MAX_SLOTS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  gha_in_if.sink                  in_i,
  input  logic [IDX_W-1:0]        sp_rdata_i,
  input  logic [IDX_W-1:0]        dn_rd_idx_i,
  input  logic [VERSION_BITS-1:0] dn_rd_ver_i,
  output gha_mem_req_t            mem_req_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output gha_res_t                res_o,
  output logic [CNT_W-1:0]        alive_o,
  output logic [CNT_W-1:0]        slot_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_ALLOC_RD, S_SP_WAIT, S_DN_WAIT, S_LAST_WAIT, S_SWAP, S_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic [GHA_OP_W-1:0]      op_q, op_d;
  logic [GHA_IDX_FLD_W-1:0] idx_q, idx_d;
  logic [GHA_VER_FLD_W-1:0] ver_q, ver_d;
  logic [IDX_W-1:0]         pos_q, pos_d;
  logic [VERSION_BITS-1:0]  newver_q, newver_d;
  logic [CNT_W-1:0]         alive_q, alive_d;
  logic [CNT_W-1:0]         slot_q, slot_d;
  gha_res_t                 res_q, res_d;

  logic [IDX_W-1:0]         lastpos;
  logic [VERSION_BITS-1:0]  bumped;
  logic                     entry_match;

  assign lastpos     = IDX_W'(alive_q - 1'b1);
  assign bumped      = VERSION_BITS'(dn_rd_ver_i + 1'b1);
  assign entry_match = (32'(dn_rd_idx_i) == 32'(idx_q)) && (32'(dn_rd_ver_i) == 32'(ver_q));

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    ver_d       = ver_q;
    pos_d       = pos_q;
    newver_d    = newver_q;
    alive_d     = alive_q;
    slot_d      = slot_q;
    res_d       = res_q;
    mem_req_o   = '0;
    in_i.ready  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.op;
          idx_d   = in_i.handle_index;
          ver_d   = in_i.handle_version;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d = '{result_index: idx_q, result_version: ver_q, handle_valid: 1'b0,
                  status: GHA_ST_OK};
        state_d = S_DONE;
        case (op_q)
          GHA_OP_ALLOC: begin
            if (alive_q < slot_q) begin
              // reuse the first dead entry
              mem_req_o.dn_raddr = GHA_IDX_MAX_W'(alive_q);
              state_d            = S_ALLOC_RD;
            end else if (slot_q == CNT_W'(MAX_SLOTS)) begin
              res_d.status = GHA_ST_FULL;
            end else begin
              mem_req_o.sp_we        = 1'b1;
              mem_req_o.sp_waddr     = GHA_IDX_MAX_W'(slot_q);
              mem_req_o.sp_wdata     = GHA_IDX_MAX_W'(slot_q);
              mem_req_o.dn_we        = 1'b1;
              mem_req_o.dn_waddr     = GHA_IDX_MAX_W'(slot_q);
              mem_req_o.dn_wdata_idx = GHA_IDX_MAX_W'(slot_q);
              mem_req_o.dn_wdata_ver = '0;
              slot_d                 = slot_q + 1'b1;
              alive_d                = alive_q + 1'b1;
              res_d.result_index     = GHA_IDX_FLD_W'(slot_q);
              res_d.result_version   = '0;
              res_d.handle_valid     = 1'b1;
            end
          end
          GHA_OP_RELEASE, GHA_OP_CHECK: begin
            if (32'(idx_q) < 32'(slot_q)) begin
              mem_req_o.sp_raddr = GHA_IDX_MAX_W'(idx_q);
              state_d            = S_SP_WAIT;
            end else begin
              res_d.status = GHA_ST_INVALID;
            end
          end
          default: ;
        endcase
      end
      S_ALLOC_RD: begin
        res_d.result_index   = GHA_IDX_FLD_W'(dn_rd_idx_i);
        res_d.result_version = GHA_VER_FLD_W'(dn_rd_ver_i);
        res_d.handle_valid   = 1'b1;
        alive_d              = alive_q + 1'b1;
        state_d              = S_DONE;
      end
      S_SP_WAIT: begin
        pos_d              = sp_rdata_i;
        mem_req_o.dn_raddr = GHA_IDX_MAX_W'(sp_rdata_i);
        state_d            = S_DN_WAIT;
      end
      S_DN_WAIT: begin
        state_d = S_DONE;
        if (!entry_match) begin
          res_d.status = GHA_ST_INVALID;
        end else if (op_q == GHA_OP_CHECK) begin
          res_d.handle_valid = 1'b1;
        end else begin
          res_d.handle_valid = 1'b1;
          newver_d           = bumped;
          if ((alive_q != '0) && (CNT_W'(pos_q) == alive_q - 1'b1)) begin
            // last alive entry: bump and shrink
            mem_req_o.dn_we        = 1'b1;
            mem_req_o.dn_waddr     = GHA_IDX_MAX_W'(pos_q);
            mem_req_o.dn_wdata_idx = GHA_IDX_MAX_W'(idx_q);
            mem_req_o.dn_wdata_ver = GHA_VER_MAX_W'(bumped);
            alive_d                = alive_q - 1'b1;
          end else if (CNT_W'(pos_q) < alive_q) begin
            // fetch the last alive entry for the swap
            mem_req_o.dn_raddr = GHA_IDX_MAX_W'(lastpos);
            state_d            = S_LAST_WAIT;
          end else begin
            // dead entry: bump only
            mem_req_o.dn_we        = 1'b1;
            mem_req_o.dn_waddr     = GHA_IDX_MAX_W'(pos_q);
            mem_req_o.dn_wdata_idx = GHA_IDX_MAX_W'(idx_q);
            mem_req_o.dn_wdata_ver = GHA_VER_MAX_W'(bumped);
          end
        end
      end
      S_LAST_WAIT: begin
        // move the last alive entry into the freed position
        mem_req_o.dn_we        = 1'b1;
        mem_req_o.dn_waddr     = GHA_IDX_MAX_W'(pos_q);
        mem_req_o.dn_wdata_idx = GHA_IDX_MAX_W'(dn_rd_idx_i);
        mem_req_o.dn_wdata_ver = GHA_VER_MAX_W'(dn_rd_ver_i);
        mem_req_o.sp_we        = 1'b1;
        mem_req_o.sp_waddr     = GHA_IDX_MAX_W'(dn_rd_idx_i);
        mem_req_o.sp_wdata     = GHA_IDX_MAX_W'(pos_q);
        state_d                = S_SWAP;
      end
      S_SWAP: begin
        mem_req_o.dn_we        = 1'b1;
        mem_req_o.dn_waddr     = GHA_IDX_MAX_W'(lastpos);
        mem_req_o.dn_wdata_idx = GHA_IDX_MAX_W'(idx_q);
        mem_req_o.dn_wdata_ver = GHA_VER_MAX_W'(newver_q);
        mem_req_o.sp_we        = 1'b1;
        mem_req_o.sp_waddr     = GHA_IDX_MAX_W'(idx_q);
        mem_req_o.sp_wdata     = GHA_IDX_MAX_W'(lastpos);
        alive_d                = alive_q - 1'b1;
        state_d                = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      alive_q <= '0;
      slot_q  <= '0;
    end else begin
      state_q  <= state_d;
      alive_q  <= alive_d;
      slot_q   <= slot_d;
      op_q     <= op_d;
      idx_q    <= idx_d;
      ver_q    <= ver_d;
      pos_q    <= pos_d;
      newver_q <= newver_d;
      res_q    <= res_d;
    end
  end

  assign res_o   = res_q;
  assign alive_o = alive_q;
  assign slot_o  = slot_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gha_pkg::*;

  localparam int unsigned MAX_SLOTS     = 1024;
  localparam int unsigned VERSION_BITS  = 16;
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned MAX_REPORTS   = 30;
  localparam int unsigned N_ROWS        = 23;

  // op code the block does not define; it must echo and change nothing
  localparam logic [GHA_OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic [GHA_OP_W-1:0]      op_t;
  typedef logic [GHA_IDX_FLD_W-1:0] idx_t;
  typedef logic [GHA_VER_FLD_W-1:0] ver_t;

  typedef struct packed {
    op_t                 op;
    idx_t                idx;
    ver_t                ver;
    logic                given;
    idx_t                e_idx;
    ver_t                e_ver;
    logic                e_hv;
    logic [GHA_ST_W-1:0] e_st;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  gha_in_if  in_ch ();
  gha_out_if out_ch ();

  generational_handle_allocator #(
    .MAX_SLOTS    (MAX_SLOTS),
    .VERSION_BITS (VERSION_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Handle table mirror
  idx_t        pos_of  [MAX_SLOTS];  // slot index -> dense position
  idx_t        slot_at [MAX_SLOTS];  // dense position -> slot index
  ver_t        ver_at  [MAX_SLOTS];  // dense position -> version
  int unsigned live_n     = 0;
  int unsigned slots_made = 0;

  gha_res_t    due_results [$];
  int unsigned errors       = 0;
  int unsigned reports      = 0;
  int unsigned results_seen = 0;
  int unsigned full_seen    = 0;
  int unsigned op_count [4] = '{0, 0, 0, 0};
  int unsigned cycles       = 0;
  int unsigned send_left    = 0;
  bit          send_quiet   = 1'b0;
  bit          rush         = 1'b0;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles,
               due_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic gha_res_t predict_handle_result(op_t op, idx_t idx, ver_t ver);
    gha_res_t    r;
    int unsigned d;
    int unsigned tail;
    idx_t        moved_idx;
    idx_t        tmp_pos;
    ver_t        moved_ver;
    bit          hit;
    r.result_index   = idx;
    r.result_version = ver;
    r.handle_valid   = 1'b0;
    r.status         = GHA_ST_OK;
    hit = 1'b0;
    d   = 0;
    if (idx < slots_made) begin
      d   = pos_of[idx];
      hit = (slot_at[d] == idx) && (ver_at[d] == ver);
    end
    case (op)
      GHA_OP_ALLOC: begin
        if (live_n < slots_made) begin
          // reuse the first dead entry with the version it carries
          r.result_index   = slot_at[live_n];
          r.result_version = ver_at[live_n];
          r.handle_valid   = 1'b1;
          live_n++;
        end else if (slots_made >= MAX_SLOTS) begin
          r.status = GHA_ST_FULL;
        end else begin
          pos_of[slots_made]  = idx_t'(slots_made);
          slot_at[slots_made] = idx_t'(slots_made);
          ver_at[slots_made]  = '0;
          r.result_index      = idx_t'(slots_made);
          r.result_version    = '0;
          r.handle_valid      = 1'b1;
          slots_made++;
          live_n++;
        end
      end
      GHA_OP_RELEASE: begin
        if (!hit) begin
          r.status = GHA_ST_INVALID;
        end else begin
          ver_at[d] = ver_at[d] + 1'b1;
          if (live_n > 0 && d == live_n - 1) begin
            live_n--;
          end else if (d < live_n) begin
            // swap with the last alive entry, then shrink
            tail          = live_n - 1;
            moved_idx     = slot_at[tail];
            moved_ver     = ver_at[tail];
            slot_at[tail] = slot_at[d];
            ver_at[tail]  = ver_at[d];
            slot_at[d]    = moved_idx;
            ver_at[d]     = moved_ver;
            tmp_pos           = pos_of[moved_idx];
            pos_of[moved_idx] = pos_of[idx];
            pos_of[idx]       = tmp_pos;
            live_n--;
          end
          r.handle_valid = 1'b1;
        end
      end
      GHA_OP_CHECK: begin
        if (hit) r.handle_valid = 1'b1;
        else r.status = GHA_ST_INVALID;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Pick a handle that exists, mostly alive, sometimes with a stale version
  function automatic void pick_handle(output idx_t idx, output ver_t ver,
                                      input int unsigned stale_pct);
    int unsigned p;
    if (live_n > 0 && $urandom_range(0, 3) != 0) p = $urandom_range(0, live_n - 1);
    else p = $urandom_range(0, slots_made - 1);
    idx = slot_at[p];
    ver = ver_at[p];
    if ($urandom_range(0, 99) < stale_pct)
      ver = ver + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
  endfunction

  task automatic send_item(op_t op, idx_t idx, ver_t ver, bit given, gha_res_t given_res);
    int unsigned gap;
    gha_res_t    predicted;
    if (send_left == 0) begin
      send_left  = $urandom_range(20, 60);
      send_quiet = ($urandom_range(0, 2) == 0);
    end
    send_left--;
    gap = (rush || send_quiet) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.handle_index   <= idx;
    in_ch.handle_version <= ver;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    predicted = predict_handle_result(op, idx, ver);
    due_results.push_back(given ? given_res : predicted);
    op_count[op]++;
  endtask

  task automatic random_item(int unsigned alloc_pct);
    int unsigned r;
    op_t         op;
    idx_t        idx;
    ver_t        ver;
    r   = $urandom_range(0, 99);
    op  = GHA_OP_ALLOC;
    idx = idx_t'($urandom_range(0, 1023));
    ver = ver_t'($urandom_range(0, 65535));
    if (r < alloc_pct) begin
      op = GHA_OP_ALLOC;
    end else if (slots_made > 0 && r < alloc_pct + 25) begin
      op = GHA_OP_RELEASE;
      pick_handle(idx, ver, 10);
    end else if (slots_made > 0 && r < alloc_pct + 40) begin
      op = GHA_OP_CHECK;
      pick_handle(idx, ver, 25);
    end else begin
      op = op_t'($urandom_range(0, 3));
    end
    send_item(op, idx, ver, 1'b0, '0);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (reports < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      reports++;
    end
  endfunction

  task automatic check_result();
    gha_res_t want;
    results_seen++;
    if (out_ch.status == GHA_ST_FULL) full_seen++;
    if (due_results.size() == 0) begin
      errors++;
      if (reports < MAX_REPORTS)
        $display("%0t: result with nothing expected, got index %0h version %0h valid %0b status %0d",
                 $time, out_ch.result_index, out_ch.result_version, out_ch.handle_valid,
                 out_ch.status);
      reports++;
      return;
    end
    want = due_results.pop_front();
    compare_field("result_index",   32'(want.result_index),   32'(out_ch.result_index));
    compare_field("result_version", 32'(want.result_version), 32'(out_ch.result_version));
    compare_field("handle_valid",   32'(want.handle_valid),   32'(out_ch.handle_valid));
    compare_field("status",         32'(want.status),         32'(out_ch.status));
  endtask

  initial begin : result_sink
    int unsigned gap;
    int unsigned left;
    bit          quiet;
    left  = 0;
    quiet = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (left == 0) begin
        left  = $urandom_range(20, 60);
        quiet = ($urandom_range(0, 2) == 0);
      end
      left--;
      gap = (rush || quiet) ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      check_result();
    end
  end

  initial begin : stimulus
    stim_row_t   rows [N_ROWS];
    gha_res_t    given;
    int unsigned k;

    // op, index, version, typed, expected index, version, valid, status
    rows = '{
      '{GHA_OP_CHECK,   10'd0,   16'd0,     1'b1, 10'd0,   16'd0,     1'b0, GHA_ST_INVALID},
      '{GHA_OP_RELEASE, 10'h3FF, 16'hFFFF,  1'b1, 10'h3FF, 16'hFFFF,  1'b0, GHA_ST_INVALID},
      '{OP_UNUSED,      10'h3FF, 16'hFFFF,  1'b1, 10'h3FF, 16'hFFFF,  1'b0, GHA_ST_OK},
      '{GHA_OP_ALLOC,   10'h2AA, 16'h5555,  1'b1, 10'd0,   16'd0,     1'b1, GHA_ST_OK},
      '{GHA_OP_ALLOC,   10'h155, 16'hAAAA,  1'b1, 10'd1,   16'd0,     1'b1, GHA_ST_OK},
      '{GHA_OP_ALLOC,   10'h3FF, 16'hFFFF,  1'b1, 10'd2,   16'd0,     1'b1, GHA_ST_OK},
      '{GHA_OP_CHECK,   10'd1,   16'd0,     1'b1, 10'd1,   16'd0,     1'b1, GHA_ST_OK},
      '{GHA_OP_CHECK,   10'd1,   16'd1,     1'b1, 10'd1,   16'd1,     1'b0, GHA_ST_INVALID},
      '{GHA_OP_RELEASE, 10'd0,   16'd0,     1'b1, 10'd0,   16'd0,     1'b1, GHA_ST_OK},
      '{GHA_OP_CHECK,   10'd0,   16'd0,     1'b1, 10'd0,   16'd0,     1'b0, GHA_ST_INVALID},
      // check a dead entry, release it twice (second is stale), then reuse it
      '{GHA_OP_CHECK,   10'd0,   16'd1,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_RELEASE, 10'd0,   16'd1,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_RELEASE, 10'd0,   16'd1,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_ALLOC,   10'd0,   16'd0,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      // release from the middle, then the last alive twice
      '{GHA_OP_RELEASE, 10'd1,   16'd0,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_RELEASE, 10'd0,   16'd2,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_RELEASE, 10'd2,   16'd0,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_ALLOC,   10'd0,   16'd0,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_ALLOC,   10'd0,   16'd0,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_ALLOC,   10'd0,   16'd0,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_ALLOC,   10'd0,   16'd0,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_CHECK,   10'd3,   16'd0,     1'b0, 10'd0,   16'd0,     1'b0, GHA_ST_OK},
      '{GHA_OP_CHECK,   10'h3FF, 16'hFFFF,  1'b1, 10'h3FF, 16'hFFFF,  1'b0, GHA_ST_INVALID}
    };

    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.op             = GHA_OP_ALLOC;
    in_ch.handle_index   = '0;
    in_ch.handle_version = '0;
    out_ch.ready         = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      given.result_index   = rows[i].e_idx;
      given.result_version = rows[i].e_ver;
      given.handle_valid   = rows[i].e_hv;
      given.status         = rows[i].e_st;
      send_item(rows[i].op, rows[i].idx, rows[i].ver, rows[i].given, given);
    end

    for (k = 0; k < 300; k++) random_item(40);
    wait_drain();

    // Lean toward releases and checks, then a burst with both sides always ready
    for (k = 0; k < 240; k++) random_item(30);
    wait_drain();
    rush = 1'b1;
    for (k = 0; k < 40; k++) random_item(45);
    rush = 1'b0;

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, oldest expected index %0h version %0h",
               $time, due_results.size(), due_results[0].result_index,
               due_results[0].result_version);
    end

    $display("Sent %0d allocate, %0d release, %0d check, %0d unused-op items; %0d results seen.",
             op_count[GHA_OP_ALLOC], op_count[GHA_OP_RELEASE], op_count[GHA_OP_CHECK],
             op_count[OP_UNUSED], results_seen);
    $display("Created %0d slots, %0d alive at the end, %0d full replies.",
             slots_made, live_n, full_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> generational_handle_allocator.f
sv/gha_pkg.sv
sv/gha_if.sv
sv/gha_store.sv
sv/gha_seq.sv
sv/generational_handle_allocator.sv
tb/tb_top.sv
